[rtl/cwsb_pkg.sv]
// ----------------------------------------------------------------------------
// cwsb_pkg: shared types and constants for the centered wrap shift blit
// Sizes, register indexes, the derived frame plan and the queued item.
// ----------------------------------------------------------------------------
package cwsb_pkg;

  // Size limits of the block
  localparam int MAX_SRC_DIM  = 4096;
  localparam int MAX_DST_DIM  = 1024;
  localparam int MAX_CHANNELS = 4;

  // Derived widths
  localparam int SW   = $clog2(MAX_SRC_DIM + 1);   // source size
  localparam int SPW  = $clog2(MAX_SRC_DIM);       // source position
  localparam int DW   = $clog2(MAX_DST_DIM + 1);   // destination size
  localparam int DPW  = $clog2(MAX_DST_DIM);       // destination position
  localparam int AW   = (SW > DW) ? SW : DW;       // common compare width
  localparam int IDXW = 20;                        // dst_index width

  // Configuration port
  localparam int CFGW = 13;                        // write data width
  localparam int REGW = 3;                         // register index width
  localparam int SRCRW = 13;                       // raw source size width
  localparam int DSTRW = 11;                       // raw destination size width
  localparam int SHW  = 11;                        // shift register width

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPW     = $clog2(Q_DEPTH);

  typedef enum logic [REGW-1:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_CHANNEL_MODE = 3'd2,
    REG_DST_WIDTH    = 3'd3,
    REG_DST_HEIGHT   = 3'd4,
    REG_DST_CHANNELS = 3'd5,
    REG_SHIFT_X      = 3'd6,
    REG_SHIFT_Y      = 3'd7
  } reg_idx_t;

  // Frame plan derived from the configuration registers
  typedef struct packed {
    logic [SW-1:0]  sw;
    logic [SW-1:0]  sh;
    logic [DW-1:0]  dw;
    logic [DW-1:0]  dh;
    logic [SPW-1:0] src_off_x;
    logic [SPW-1:0] src_off_y;
    logic [DW-1:0]  count_x;
    logic [DW-1:0]  count_y;
    logic [DPW-1:0] start_x;
    logic [DPW-1:0] start_y;
    logic [2:0]     zs;
    logic [2:0]     zc;
    logic           rev;
  } plan_t;

  // Kept pixel on its way from front to back
  typedef struct packed {
    logic [DPW-1:0]  kx;
    logic [DPW-1:0]  ky;
    logic [3:0][7:0] ch;
    logic            done;
  } item_t;

endpackage

[rtl/cwsb_plan.sv]
// ----------------------------------------------------------------------------
// cwsb_plan: configuration registers and frame plan
// Holds the registers, clamps sizes, works out crop/center offsets and the
// wrapped start position with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module cwsb_plan import cwsb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [REGW-1:0] cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  output plan_t           plan,
  output logic            busy
);

  localparam int MW   = ((DW > SHW) ? DW : SHW) + 1;  // magnitude width
  localparam int VW   = MW + 1;                       // signed sum width
  localparam int CNTW = $clog2(MW);
  localparam int CLS  = (SW > SRCRW) ? SW : SRCRW;
  localparam int CLD  = (DW > DSTRW) ? DW : DSTRW;

  typedef enum logic [1:0] {P_LOAD, P_DIV, P_FIX, P_IDLE} pstate_t;

  typedef struct packed {
    logic [SPW-1:0] src_off;
    logic [DPW-1:0] dst_off;
    logic [DW-1:0]  count;
  } axis_t;

  // Registers
  logic [SRCRW-1:0] src_width, src_height;
  logic [2:0]       channel_mode;
  logic [DSTRW-1:0] dst_width, dst_height;
  logic [2:0]       dst_channels;
  logic [SHW-1:0]   shift_x, shift_y;

  pstate_t          state;
  logic [MW-1:0]    mag_x, mag_y;
  logic [DW-1:0]    rem_x, rem_y;
  logic             neg_x, neg_y;
  logic [CNTW-1:0]  bit_cnt;

  // Load-time values
  logic [SW-1:0]  sw_c, sh_c;
  logic [DW-1:0]  dw_c, dh_c;
  logic [2:0]     zd_c, zs_c, zc_c;
  axis_t          ax, ay;
  logic [VW-1:0]  v_x, v_y, a_x, a_y;

  // Remainder step
  logic [DW:0]    trial_x, trial_y;
  logic [DW-1:0]  rem_x_next, rem_y_next;

  function automatic logic [SW-1:0] clamp_src(input logic [SRCRW-1:0] raw);
    logic [CLS-1:0] v;
    v = CLS'(raw);
    if (v == '0) return SW'(1);
    if (v > CLS'(MAX_SRC_DIM)) return SW'(MAX_SRC_DIM);
    return SW'(v);
  endfunction

  function automatic logic [DW-1:0] clamp_dst(input logic [DSTRW-1:0] raw);
    logic [CLD-1:0] v;
    v = CLD'(raw);
    if (v == '0) return DW'(1);
    if (v > CLD'(MAX_DST_DIM)) return DW'(MAX_DST_DIM);
    return DW'(v);
  endfunction

  // Center a smaller source, crop a larger one
  function automatic axis_t plan_axis(input logic [SW-1:0] s, input logic [DW-1:0] d);
    axis_t          p;
    logic [AW-1:0]  se, de, diff;
    se   = AW'(s);
    de   = AW'(d);
    p    = '0;
    diff = '0;
    if (se < de) begin
      diff      = de - se;
      p.dst_off = DPW'(diff >> 1);
      p.count   = DW'(s);
    end else if (se > de) begin
      diff      = se - de;
      p.src_off = SPW'(diff >> 1);
      p.count   = d;
    end else begin
      p.count   = d;
    end
    return p;
  endfunction

  // Clamp and plan both axes from the raw registers
  always_comb begin
    sw_c = clamp_src(src_width);
    sh_c = clamp_src(src_height);
    dw_c = clamp_dst(dst_width);
    dh_c = clamp_dst(dst_height);
    if (dst_channels == 3'd0) begin
      zd_c = 3'd1;
    end else if (dst_channels > 3'(MAX_CHANNELS)) begin
      zd_c = 3'(MAX_CHANNELS);
    end else begin
      zd_c = dst_channels;
    end
    zs_c = {1'b0, channel_mode[1:0]} + 3'd1;
    zc_c = (zd_c < zs_c) ? zd_c : zs_c;
    ax   = plan_axis(sw_c, dw_c);
    ay   = plan_axis(sh_c, dh_c);
    v_x  = VW'(ax.dst_off) + {{(VW-SHW){shift_x[SHW-1]}}, shift_x};
    v_y  = VW'(ay.dst_off) + {{(VW-SHW){shift_y[SHW-1]}}, shift_y};
    a_x  = v_x[VW-1] ? (VW'(0) - v_x) : v_x;
    a_y  = v_y[VW-1] ? (VW'(0) - v_y) : v_y;
  end

  // One restoring remainder step per cycle, both axes side by side
  always_comb begin
    trial_x = {rem_x, mag_x[MW-1]};
    trial_y = {rem_y, mag_y[MW-1]};
    if (trial_x >= (DW+1)'(plan.dw)) begin
      rem_x_next = DW'(trial_x - (DW+1)'(plan.dw));
    end else begin
      rem_x_next = DW'(trial_x);
    end
    if (trial_y >= (DW+1)'(plan.dh)) begin
      rem_y_next = DW'(trial_y - (DW+1)'(plan.dh));
    end else begin
      rem_y_next = DW'(trial_y);
    end
  end

  assign busy = (state != P_IDLE);

  // Register writes and plan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= SRCRW'(1);
      src_height   <= SRCRW'(1);
      channel_mode <= 3'd3;
      dst_width    <= DSTRW'(1024);
      dst_height   <= DSTRW'(1024);
      dst_channels <= 3'd4;
      shift_x      <= '0;
      shift_y      <= '0;
      state        <= P_LOAD;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_WIDTH:    src_width    <= cfg_data[SRCRW-1:0];
        REG_SRC_HEIGHT:   src_height   <= cfg_data[SRCRW-1:0];
        REG_CHANNEL_MODE: channel_mode <= cfg_data[2:0];
        REG_DST_WIDTH:    dst_width    <= cfg_data[DSTRW-1:0];
        REG_DST_HEIGHT:   dst_height   <= cfg_data[DSTRW-1:0];
        REG_DST_CHANNELS: dst_channels <= cfg_data[2:0];
        REG_SHIFT_X:      shift_x      <= cfg_data[SHW-1:0];
        REG_SHIFT_Y:      shift_y      <= cfg_data[SHW-1:0];
        default: ;
      endcase
      state <= P_LOAD;
    end else begin
      case (state)
        P_LOAD: begin
          plan.sw        <= sw_c;
          plan.sh        <= sh_c;
          plan.dw        <= dw_c;
          plan.dh        <= dh_c;
          plan.src_off_x <= ax.src_off;
          plan.src_off_y <= ay.src_off;
          plan.count_x   <= ax.count;
          plan.count_y   <= ay.count;
          plan.zs        <= zs_c;
          plan.zc        <= zc_c;
          plan.rev       <= channel_mode[2];
          neg_x          <= v_x[VW-1];
          neg_y          <= v_y[VW-1];
          mag_x          <= a_x[MW-1:0];
          mag_y          <= a_y[MW-1:0];
          rem_x          <= '0;
          rem_y          <= '0;
          bit_cnt        <= CNTW'(MW - 1);
          state          <= P_DIV;
        end
        P_DIV: begin
          rem_x   <= rem_x_next;
          rem_y   <= rem_y_next;
          mag_x   <= {mag_x[MW-2:0], 1'b0};
          mag_y   <= {mag_y[MW-2:0], 1'b0};
          bit_cnt <= bit_cnt - CNTW'(1);
          if (bit_cnt == '0) begin
            state <= P_FIX;
          end
        end
        P_FIX: begin
          // negative sum: fold the remainder back into 0..size-1
          plan.start_x <= (neg_x && rem_x != '0) ? DPW'(plan.dw - rem_x) : DPW'(rem_x);
          plan.start_y <= (neg_y && rem_y != '0) ? DPW'(plan.dh - rem_y) : DPW'(rem_y);
          state        <= P_IDLE;
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/cwsb_front.sv]
// ----------------------------------------------------------------------------
// cwsb_front: input acceptance and pixel classification
// Tracks the raster position, decides keep or drop, converts channels and
// pushes kept items into the queue.
// ----------------------------------------------------------------------------
module cwsb_front import cwsb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch0,
  input  logic [7:0] in_ch1,
  input  logic [7:0] in_ch2,
  input  logic [7:0] in_ch3,
  input  plan_t      plan,
  input  logic       plan_busy,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  logic [SPW-1:0] source_column, source_row;

  logic            accept, keep_x, keep_y;
  logic [AW-1:0]   c_ext, r_ext, dx, dy;
  logic [AW:0]     c1, r1;
  logic [7:0]      src [4];
  logic [2:0]      sel, sj;
  logic [3:0][7:0] ch_conv;

  assign in_stall = plan_busy || q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && keep_x && keep_y;

  // Window test and position inside the kept window
  always_comb begin
    c_ext  = AW'(source_column);
    r_ext  = AW'(source_row);
    dx     = c_ext - AW'(plan.src_off_x);
    dy     = r_ext - AW'(plan.src_off_y);
    keep_x = (c_ext >= AW'(plan.src_off_x)) && (dx < AW'(plan.count_x));
    keep_y = (r_ext >= AW'(plan.src_off_y)) && (dy < AW'(plan.count_y));
    push_item.kx   = dx[DPW-1:0];
    push_item.ky   = dy[DPW-1:0];
    push_item.ch   = ch_conv;
    push_item.done = (DW'(dx[DPW-1:0]) == plan.count_x - DW'(1)) &&
                     (DW'(dy[DPW-1:0]) == plan.count_y - DW'(1));
  end

  // Channel conversion: copy the lesser count, optionally reversed
  always_comb begin
    src[0] = in_ch0;
    src[1] = in_ch1;
    src[2] = in_ch2;
    src[3] = in_ch3;
    sel    = '0;
    sj     = '0;
    for (int j = 0; j < 4; j++) begin
      sel = 3'(j);
      sj  = plan.rev ? (plan.zs - 3'd1 - sel) : sel;
      ch_conv[j] = (sel < plan.zc) ? src[sj[1:0]] : 8'd0;
    end
  end

  // Raster position update
  always_comb begin
    c1 = (AW+1)'(source_column) + (AW+1)'(1);
    r1 = (AW+1)'(source_row) + (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
    end else if (accept) begin
      if (c1 >= (AW+1)'(plan.sw)) begin
        source_column <= '0;
        source_row    <= (r1 >= (AW+1)'(plan.sh)) ? '0 : r1[SPW-1:0];
      end else begin
        source_column <= c1[SPW-1:0];
        source_row    <= ((AW+1)'(source_row) >= (AW+1)'(plan.sh)) ? '0 : source_row;
      end
    end
  end

endmodule

[rtl/cwsb_queue.sv]
// ----------------------------------------------------------------------------
// cwsb_queue: short item queue between front and back
// Register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cwsb_queue import cwsb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  nonempty,
  output logic  full
);

  item_t          mem [Q_DEPTH];
  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic [QPW:0]   count;

  assign head     = mem[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == (QPW+1)'(Q_DEPTH));

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        count <= count + (QPW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPW+1)'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/cwsb_back.sv]
// ----------------------------------------------------------------------------
// cwsb_back: placement and result output
// Stage A wraps the shifted position, stage B forms the pixel index and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module cwsb_back import cwsb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  plan_t           plan,
  input  logic            q_nonempty,
  input  item_t           q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IDXW-1:0] dst_index,
  output logic [7:0]      out_ch0,
  output logic [7:0]      out_ch1,
  output logic [7:0]      out_ch2,
  output logic [7:0]      out_ch3,
  output logic            frame_done
);

  localparam int TW = DPW + 1;
  localparam int PW = (2 * DW + 1 > IDXW) ? 2 * DW + 1 : IDXW;

  logic            a_valid, a_ready, out_ready;
  logic [DPW-1:0]  a_tc, a_tr, tc, tr;
  logic [3:0][7:0] a_ch;
  logic            a_done;
  logic [TW-1:0]   sum_x, sum_y;
  logic [PW-1:0]   idx_full;

  assign out_ready = !out_valid || !out_stall;
  assign a_ready   = !a_valid || out_ready;
  assign pop       = q_nonempty && a_ready;

  // Shift with wrap: one compare-subtract per axis
  always_comb begin
    sum_x = TW'(plan.start_x) + TW'(q_head.kx);
    sum_y = TW'(plan.start_y) + TW'(q_head.ky);
    tc = (sum_x >= TW'(plan.dw)) ? DPW'(sum_x - TW'(plan.dw)) : DPW'(sum_x);
    tr = (sum_y >= TW'(plan.dh)) ? DPW'(sum_y - TW'(plan.dh)) : DPW'(sum_y);
  end

  // Row times width plus column
  assign idx_full = PW'(a_tr) * PW'(plan.dw) + PW'(a_tc);

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= pop;
      end
      if (out_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (pop) begin
      a_tc   <= tc;
      a_tr   <= tr;
      a_ch   <= q_head.ch;
      a_done <= q_head.done;
    end
    if (out_ready && a_valid) begin
      dst_index  <= idx_full[IDXW-1:0];
      out_ch0    <= a_ch[0];
      out_ch1    <= a_ch[1];
      out_ch2    <= a_ch[2];
      out_ch3    <= a_ch[3];
      frame_done <= a_done;
    end
  end

endmodule

[rtl/centered_wrap_shift_blit_top.sv]
// ----------------------------------------------------------------------------
// centered_wrap_shift_blit_top: centered, cropped, wrap-shifted pixel blit
// Maps raster-order source pixels to destination pixel indexes and
// converted channel bytes.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid / in_stall   | in_ch0..in_ch3
//  out     | out_valid / out_stall | dst_index, out_ch0..3, frame_done
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle in and out while neither side stalls; out_valid for a
// kept pixel rises once it has passed the queue slot, then the wrap stage,
// then the index stage. After reset and after every register write the plan
// unit runs load, 12 remainder steps and fold, and holds in_stall high
// meanwhile. cfg_ready is always high. A stalled output backs up through the
// 4-entry queue; in_stall rises when the queue is full.
// ----------------------------------------------------------------------------
module centered_wrap_shift_blit_top import cwsb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_ch0,
  input  logic [7:0]      in_ch1,
  input  logic [7:0]      in_ch2,
  input  logic [7:0]      in_ch3,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IDXW-1:0] dst_index,
  output logic [7:0]      out_ch0,
  output logic [7:0]      out_ch1,
  output logic [7:0]      out_ch2,
  output logic [7:0]      out_ch3,
  output logic            frame_done,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [REGW-1:0] cfg_index,
  input  logic [CFGW-1:0] cfg_data
);

  plan_t plan;
  logic  plan_busy;
  logic  push, pop, q_nonempty, q_full;
  item_t push_item, q_head;

  assign cfg_ready = 1'b1;

  cwsb_plan u_plan (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .plan      (plan),
    .busy      (plan_busy)
  );

  cwsb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch0    (in_ch0),
    .in_ch1    (in_ch1),
    .in_ch2    (in_ch2),
    .in_ch3    (in_ch3),
    .plan      (plan),
    .plan_busy (plan_busy),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  cwsb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .nonempty  (q_nonempty),
    .full      (q_full)
  );

  cwsb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .plan       (plan),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dst_index  (dst_index),
    .out_ch0    (out_ch0),
    .out_ch1    (out_ch1),
    .out_ch2    (out_ch2),
    .out_ch3    (out_ch3),
    .frame_done (frame_done)
  );

`ifndef ASSERT_OFF
  // a register write always holds off input while the plan is redone
  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input not stalled after register write");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  // the back only pops a queue that holds an item
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_nonempty)
    else $error("queue underflow");
`endif

endmodule

[tb/sv/centered_wrap_shift_blit_checker.sv]
// ----------------------------------------------------------------------------
// centered_wrap_shift_blit_checker: result predictor and comparator
// Watches the config, input and output channels of the blit. Each accepted
// source pixel is mapped to its destination index and channel bytes, and
// every accepted output item is compared field by field against the oldest
// pending prediction. Reports a failure count and the number still pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module centered_wrap_shift_blit_checker import cwsb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [7:0]      in_ch0,
  input  logic [7:0]      in_ch1,
  input  logic [7:0]      in_ch2,
  input  logic [7:0]      in_ch3,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [IDXW-1:0] dst_index,
  input  logic [7:0]      out_ch0,
  input  logic [7:0]      out_ch1,
  input  logic [7:0]      out_ch2,
  input  logic [7:0]      out_ch3,
  input  logic            frame_done,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [REGW-1:0] cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  output int              fail_count,
  output int              pending_count
);

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic [3:0][7:0] ch;
    logic            done;
  } blit_result_t;

  // Register copies, raw as written
  logic [12:0] src_w_q, src_h_q;
  logic [2:0]  chan_mode_q;
  logic [10:0] dst_w_q, dst_h_q;
  logic [2:0]  dst_ch_q;
  logic [10:0] shift_x_q, shift_y_q;

  // Raster position of the next source pixel
  int col_pos, row_pos;

  blit_result_t expected_px[$];
  int n_err = 0;

  function automatic int clamp_dim(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // Per-axis crop/center window and the wrapped start position
  function automatic void fit_axis(input int s, input int d, input logic [10:0] shift,
                                   output int src_off, output int count, output int start);
    int dst_off;
    int v;
    if (s < d) begin
      src_off = 0; dst_off = (d - s) / 2; count = s;
    end else if (s > d) begin
      src_off = (s - d) / 2; dst_off = 0; count = d;
    end else begin
      src_off = 0; dst_off = 0; count = s;
    end
    v = (dst_off + int'($signed(shift))) % d;
    if (v < 0) v += d;
    start = v;
  endfunction

  // Maps one source pixel; returns 1 if it lands in the destination
  function automatic bit blit_pixel(input logic [3:0][7:0] src, output blit_result_t res);
    int sw, sh, dw, dh, zd, zs, zc;
    bit rev, kept;
    int ox, cx, stx, oy, cy, sty;
    int c, r, kx, ky, tc, tr, sj;
    sw = clamp_dim(src_w_q, MAX_SRC_DIM);
    sh = clamp_dim(src_h_q, MAX_SRC_DIM);
    dw = clamp_dim(dst_w_q, MAX_DST_DIM);
    dh = clamp_dim(dst_h_q, MAX_DST_DIM);
    zd = clamp_dim(dst_ch_q, MAX_CHANNELS);
    zs = chan_mode_q[1:0] + 1;
    rev = chan_mode_q[2];
    zc = (zd < zs) ? zd : zs;
    fit_axis(sw, dw, shift_x_q, ox, cx, stx);
    fit_axis(sh, dh, shift_y_q, oy, cy, sty);
    c = col_pos;
    r = row_pos;
    kept = 1'b0;
    res = '0;

    if (c >= ox && c - ox < cx && r >= oy && r - oy < cy) begin
      kx = c - ox;
      ky = r - oy;
      tc = stx + kx;
      tr = sty + ky;
      if (tc >= dw) tc -= dw;
      if (tr >= dh) tr -= dh;
      res.idx = IDXW'(tr * dw + tc);
      for (int j = 0; j < 4; j++) begin
        if (j < zc) begin
          sj = rev ? (zs - 1 - j) : j;
          res.ch[j] = src[sj];
        end
      end
      res.done = (kx == cx - 1) && (ky == cy - 1);
      kept = 1'b1;
    end

    // Advance the raster; a position past a shrunken size falls back
    if (c + 1 >= sw) begin
      col_pos = 0;
      row_pos = (r + 1 >= sh) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = (r >= sh) ? 0 : r;
    end
    return kept;
  endfunction

  function automatic int check_field(input string name, input int unsigned want,
                                     input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : track
    blit_result_t want;
    blit_result_t pred;
    if (rst) begin
      src_w_q = 13'd1;
      src_h_q = 13'd1;
      chan_mode_q = 3'd3;
      dst_w_q = 11'd1024;
      dst_h_q = 11'd1024;
      dst_ch_q = 3'd4;
      shift_x_q = '0;
      shift_y_q = '0;
      col_pos = 0;
      row_pos = 0;
      expected_px.delete();
    end else begin
      // Output item against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          $error("dst_index: expected no item, got %0d", dst_index);
          n_err++;
        end else begin
          want = expected_px.pop_front();
          n_err += check_field("dst_index", want.idx, dst_index);
          n_err += check_field("out_ch0", want.ch[0], out_ch0);
          n_err += check_field("out_ch1", want.ch[1], out_ch1);
          n_err += check_field("out_ch2", want.ch[2], out_ch2);
          n_err += check_field("out_ch3", want.ch[3], out_ch3);
          n_err += check_field("frame_done", want.done, frame_done);
        end
      end

      // Source pixel in
      if (in_valid && !in_stall) begin
        if (blit_pixel({in_ch3, in_ch2, in_ch1, in_ch0}, pred))
          expected_px.push_back(pred);
      end

      // Register write
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SRC_WIDTH:    src_w_q = cfg_data[12:0];
          REG_SRC_HEIGHT:   src_h_q = cfg_data[12:0];
          REG_CHANNEL_MODE: chan_mode_q = cfg_data[2:0];
          REG_DST_WIDTH:    dst_w_q = cfg_data[10:0];
          REG_DST_HEIGHT:   dst_h_q = cfg_data[10:0];
          REG_DST_CHANNELS: dst_ch_q = cfg_data[2:0];
          REG_SHIFT_X:      shift_x_q = cfg_data[10:0];
          REG_SHIFT_Y:      shift_y_q = cfg_data[10:0];
          default: ;
        endcase
      end
    end
    fail_count <= n_err;
    pending_count <= expected_px.size();
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the centered wrap shift blit
// Runs a short directed sequence (defaults, clamped sizes, largest index,
// crops, reversed channels, mid-frame resize, a full queue), two long
// cropped frames, then random small-frame phases with bursty input,
// patterned output stalls and long output hold-offs. The checker does the
// comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import cwsb_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RAND_PHASES    = 8;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HALF} stall_mode_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_ch0 = '0;
  logic [7:0]      in_ch1 = '0;
  logic [7:0]      in_ch2 = '0;
  logic [7:0]      in_ch3 = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [IDXW-1:0] dst_index;
  logic [7:0]      out_ch0, out_ch1, out_ch2, out_ch3;
  logic            frame_done;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [REGW-1:0] cfg_index = '0;
  logic [CFGW-1:0] cfg_data = '0;

  int fail_cnt;
  int pending_cnt;
  int burst_left = 8;
  int hold_req = 0;
  int idle_cycles = 0;
  logic any_accept;

  centered_wrap_shift_blit_top i_dut (.*);

  centered_wrap_shift_blit_checker i_blit_check (
    .*,
    .fail_count    (fail_cnt),
    .pending_count (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: cycles without any handshake
  assign any_accept = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                      (cfg_valid && cfg_ready);

  always @(posedge clk) begin
    if (rst || any_accept) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Output back-pressure: random patterns plus long hold-offs on request
  initial begin
    stall_mode_t mode;
    int span;
    int seen_hold;
    seen_hold = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != seen_hold) begin
        seen_hold = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 40);
      repeat (span) begin
        if (hold_req != seen_hold) break;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  // One register write; valid stays up for a following write
  task automatic cfg_write(input reg_idx_t idx, input logic [CFGW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_plan(input logic [CFGW-1:0] sw, sh, mode, dw, dh, dch, shx, shy);
    cfg_write(REG_SRC_WIDTH, sw);
    cfg_write(REG_SRC_HEIGHT, sh);
    cfg_write(REG_CHANNEL_MODE, mode);
    cfg_write(REG_DST_WIDTH, dw);
    cfg_write(REG_DST_HEIGHT, dh);
    cfg_write(REG_DST_CHANNELS, dch);
    cfg_write(REG_SHIFT_X, shx);
    cfg_write(REG_SHIFT_Y, shy);
    cfg_valid <= 1'b0;
  endtask

  // Source pixel; bursts of random length separated by random gaps
  task automatic push_pixel(input logic [31:0] px);
    in_valid <= 1'b1;
    {in_ch3, in_ch2, in_ch1, in_ch0} <= px;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic push_random(input int n);
    repeat (n) push_pixel($urandom());
  endtask

  // Drain all predicted items, then let dropped pixels clear the pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset plan: 1x1 source centered in 1024x1024
    push_pixel(32'h0000_0000);
    push_pixel(32'hFFFF_FFFF);

    // Largest index, over-range sizes and channel counts, reversed 4 channels
    wait_idle();
    set_plan(13'd1, 13'd1, 13'd7, 13'h07FF, 13'h1FFF, 13'd7, 13'd512, 13'd512);
    push_pixel(32'h4433_2211);
    push_pixel(32'h8040_2010);

    // X crop, Y center, shift of -1024 and +1023, 2 -> 3 channels
    wait_idle();
    set_plan(13'd3, 13'd2, 13'd1, 13'd2, 13'd4, 13'd3, 13'h0400, 13'd1023);
    push_random(6);

    // Zero sizes and zero channel count clamp up, 3 channels reversed
    wait_idle();
    set_plan(13'd0, 13'd2, 13'd6, 13'd0, 13'd1, 13'd0, 13'd0, 13'd0);
    push_random(3);

    // Equal sizes, small shifts both ways, single reversed channel
    wait_idle();
    set_plan(13'd2, 13'd2, 13'd4, 13'd2, 13'd2, 13'd2, 13'd1, 13'h07FF);
    push_random(3);

    // Width shrinks under a frame in progress
    wait_idle();
    set_plan(13'd1, 13'd2, 13'd4, 13'd2, 13'd2, 13'd2, 13'd1, 13'h07FF);
    push_random(3);

    // Every pixel kept while the output is held off: queue fills, input stalls
    wait_idle();
    set_plan(13'd8, 13'd8, 13'd3, 13'd10, 13'd10, 13'd4, 13'd3, 13'h07FE);
    hold_req <= hold_req + 1;
    push_random(40);

    // Wide source cropped to the widest destination, start wraps at once
    wait_idle();
    set_plan(13'd1100, 13'd1, 13'd2, 13'd1024, 13'd1, 13'd4, 13'h1BFF, 13'd0);
    push_random(200);

    // Tall source cropped to the tallest destination
    wait_idle();
    set_plan(13'd1, 13'd1200, 13'd3, 13'd5, 13'd1024, 13'd4, 13'd0, 13'h1C01);
    push_random(200);

    // Random small frames; some phases open with a long output hold-off
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      set_plan(CFGW'($urandom_range(0, 9)), CFGW'($urandom_range(0, 9)),
               CFGW'($urandom_range(0, 7)), CFGW'($urandom_range(1, 10)),
               CFGW'($urandom_range(1, 10)), CFGW'($urandom_range(0, 7)),
               CFGW'($urandom_range(0, 8191)), CFGW'($urandom_range(0, 8191)));
      if (p % 3 == 0) hold_req <= hold_req + 1;
      push_random($urandom_range(25, 45));
    end

    wait_idle();
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
